// ----- hdl/ftt_pkg.sv -----
// shared types and constants of the flow table with timeouts
package ftt_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned ProtoW  = 8;
  localparam int unsigned PktByteW = 16;
  localparam int unsigned BytesW  = 40;
  localparam int unsigned CountW  = 32;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned MaxResults = 32;

  localparam logic [AddrW-1:0]  LocalAddrRst = 32'h0000_0000;
  localparam logic [AddrW-1:0]  AltAddrRst   = 32'hC0A8_2401;
  localparam logic [LimitW-1:0] IdleLimRst   = 16'd60;
  localparam logic [LimitW-1:0] ActLimRst    = 16'd300;
  localparam logic [LimitW-1:0] PeriodRst    = 16'd10;

  localparam logic [BytesW-1:0] BytesMax   = '1;
  localparam logic [CountW-1:0] PacketsMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LOCAL_ADDR = 3'd0,
    REG_ALT_ADDR   = 3'd1,
    REG_IDLE_LIM   = 3'd2,
    REG_ACT_LIM    = 3'd3,
    REG_PERIOD     = 3'd4
  } reg_idx_e;

  typedef enum logic {
    OP_PACKET = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_EXPORT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_CREATED = 2'd0,
    ST_UPDATED = 2'd1,
    ST_SKIPPED = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic {
    CAUSE_IDLE   = 1'b0,
    CAUSE_ACTIVE = 1'b1
  } cause_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PKT,
    S_SWP,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic [AddrW-1:0]  home_addr;
    logic [AddrW-1:0]  alt_addr;
    logic [LimitW-1:0] idle_lim;
    logic [LimitW-1:0] act_lim;
    logic [LimitW-1:0] period;
  } cfg_t;

  typedef struct packed {
    logic [AddrW-1:0]  source;
    logic [AddrW-1:0]  dest;
    logic [ProtoW-1:0] proto;
    logic [BytesW-1:0] bytes;
    logic [CountW-1:0] packets;
    logic [TimeW-1:0]  start;
    logic [TimeW-1:0]  last;
  } entry_t;

  typedef struct packed {
    logic [AddrW-1:0]    source;
    logic [AddrW-1:0]    dest;
    logic [ProtoW-1:0]   proto;
    logic [PktByteW-1:0] bytes;
  } pkt_t;

  typedef struct packed {
    logic              kind;
    logic [1:0]        status;
    logic [AddrW-1:0]  source;
    logic [AddrW-1:0]  dest;
    logic [ProtoW-1:0] proto;
    logic [BytesW-1:0] bytes;
    logic [CountW-1:0] packets;
    logic [TimeW-1:0]  duration;
    logic              cause;
    logic              last;
  } rec_t;

endpackage

// ----- hdl/ftt_if.sv -----
// request and result channel interfaces of the flow table
interface ftt_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [7:0]  proto_number;
  logic [15:0] byte_count;

  modport source (output valid, operation, source_address, dest_address, proto_number,
                  byte_count, input ready);
  modport sink (input valid, operation, source_address, dest_address, proto_number,
                byte_count, output ready);
endinterface

interface ftt_rsp_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [1:0]  status;
  logic [31:0] flow_source;
  logic [31:0] flow_dest;
  logic [7:0]  flow_proto;
  logic [39:0] flow_bytes;
  logic [31:0] flow_packets;
  logic [31:0] flow_duration;
  logic        expire_cause;
  logic        last_of_run;

  modport source (output valid, record_kind, status, flow_source, flow_dest, flow_proto,
                  flow_bytes, flow_packets, flow_duration, expire_cause, last_of_run,
                  input ready);
  modport sink (input valid, record_kind, status, flow_source, flow_dest, flow_proto,
                flow_bytes, flow_packets, flow_duration, expire_cause, last_of_run,
                output ready);
endinterface

// ----- hdl/ftt_cfg.sv -----
// configuration register file of the flow table
module ftt_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ftt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ftt_pkg::CfgDataW-1:0] cfg_data_i,
  output ftt_pkg::cfg_t            cfg_o
);
  import ftt_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOCAL_ADDR: cfg_d.home_addr = cfg_data_i;
        REG_ALT_ADDR:   cfg_d.alt_addr  = cfg_data_i;
        REG_IDLE_LIM:   cfg_d.idle_lim  = cfg_data_i[LimitW-1:0];
        REG_ACT_LIM:    cfg_d.act_lim   = cfg_data_i[LimitW-1:0];
        REG_PERIOD:     cfg_d.period    = cfg_data_i[LimitW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.home_addr <= LocalAddrRst;
      cfg_q.alt_addr  <= AltAddrRst;
      cfg_q.idle_lim  <= IdleLimRst;
      cfg_q.act_lim   <= ActLimRst;
      cfg_q.period    <= PeriodRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/flow_table_with_timeouts.sv -----
// top level of the flow table with idle and active timeouts
//
// requests arrive on req_i: a packet (source, destination, protocol, bytes) or a
// one-second tick. results leave on rsp_o, each with last_of_run set on the final
// result that a request causes. configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user is to write it only while the block is idle,
// which the block itself does not enforce. a packet to a foreign destination
// gives its skipped status through the holding and output registers. a local
// packet reads the entry memory one entry a cycle: a hit ends the search at the
// matching entry, a miss (create or full) reads every entry. a tick without a
// sweep gives no result. a sweep reads each entry at most once and exports at
// most 32 flows; one record is held back until the next is found so that the
// last one can be marked. the entry memory port gives one read a cycle, none
// while a sweep stalls; one request is handled at a time and req_i.ready is
// high only between requests. a stalled receiver holds the output register;
// the sweep waits only when a second record is ready and both holding registers
// are full. reset clears the valid bits, the time and the sweep counter and
// loads the register defaults; entry memory contents need no clearing.
module flow_table_with_timeouts #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ftt_req_if.sink                      req_i,
  ftt_rsp_if.source                    rsp_o,
  input  logic                         cfg_we_i,
  input  logic [ftt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ftt_pkg::CfgDataW-1:0] cfg_data_i
);
  import ftt_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NW = $clog2(MaxResults + 1);

  cfg_t cfg;

  ftt_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  function automatic rec_t rec_of(entry_t e, logic kind, logic [1:0] st, logic cause);
    rec_t r;
    r.kind     = kind;
    r.status   = st;
    r.source   = e.source;
    r.dest     = e.dest;
    r.proto    = e.proto;
    r.bytes    = e.bytes;
    r.packets  = e.packets;
    r.duration = e.last - e.start;
    r.cause    = cause;
    r.last     = 1'b0;
    return r;
  endfunction

  state_e state_q, state_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic          chk_vld_q, chk_vld_d;
  logic [IW-1:0] chk_idx_q, chk_idx_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic          free_fnd_q, free_fnd_d;
  logic [IW-1:0] free_idx_q, free_idx_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          pend_vld_q, pend_vld_d;
  rec_t          pend_q, pend_d;
  logic          out_vld_q, out_vld_d;
  rec_t          out_q, out_d;
  pkt_t          pkt_q, pkt_d;
  logic [TimeW-1:0]  now_q, now_d;
  logic [LimitW-1:0] swc_q, swc_d;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;
  logic          rd_en;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;

  logic          out_free, rd_more, hit, expire, exp_idle, stall;
  logic [AddrW-1:0] plo, phi, elo, ehi;
  logic [BytesW:0]  bsum;
  logic [TimeW-1:0] idle_age, act_age;
  logic [LimitW-1:0] swc_inc;
  entry_t        upd, crt;

  assign out_free = !out_vld_q || rsp_o.ready;
  assign rd_more  = rd_idx_q != CW'(TABLE_DEPTH);

  // direction-normalized keys
  assign plo = (pkt_q.source < pkt_q.dest) ? pkt_q.source : pkt_q.dest;
  assign phi = (pkt_q.source < pkt_q.dest) ? pkt_q.dest : pkt_q.source;
  assign elo = (rd_q.source < rd_q.dest) ? rd_q.source : rd_q.dest;
  assign ehi = (rd_q.source < rd_q.dest) ? rd_q.dest : rd_q.source;
  assign hit = chk_vld_q && valid_q[chk_idx_q] && (elo == plo) && (ehi == phi)
               && (rd_q.proto == pkt_q.proto);

  assign idle_age = now_q - rd_q.last;
  assign act_age  = now_q - rd_q.start;
  assign exp_idle = idle_age >= TimeW'(cfg.idle_lim);
  assign expire   = chk_vld_q && valid_q[chk_idx_q]
                    && (exp_idle || (act_age >= TimeW'(cfg.act_lim)));
  assign stall    = expire && pend_vld_q && !out_free;

  assign swc_inc = swc_q + LimitW'(1);
  assign bsum    = {1'b0, rd_q.bytes} + (BytesW + 1)'(pkt_q.bytes);

  always_comb begin
    upd = rd_q;
    upd.bytes   = bsum[BytesW] ? BytesMax : bsum[BytesW-1:0];
    upd.packets = (rd_q.packets == PacketsMax) ? rd_q.packets : rd_q.packets + CountW'(1);
    upd.last    = now_q;
    crt.source  = pkt_q.source;
    crt.dest    = pkt_q.dest;
    crt.proto   = pkt_q.proto;
    crt.bytes   = BytesW'(pkt_q.bytes);
    crt.packets = CountW'(1);
    crt.start   = now_q;
    crt.last    = now_q;
  end

  always_comb begin
    state_d    = state_q;
    rd_idx_d   = rd_idx_q;
    chk_vld_d  = chk_vld_q;
    chk_idx_d  = chk_idx_q;
    valid_d    = valid_q;
    free_fnd_d = free_fnd_q;
    free_idx_d = free_idx_q;
    cnt_d      = cnt_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q && !rsp_o.ready;
    out_d      = out_q;
    pkt_d      = pkt_q;
    now_d      = now_q;
    swc_d      = swc_q;
    rd_en      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = free_idx_q;
    mem_wdata  = crt;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.operation == OP_TICK) begin
            now_d = now_q + TimeW'(1);
            if (swc_inc < cfg.period) begin
              swc_d = swc_inc;
            end else begin
              swc_d     = '0;
              rd_idx_d  = '0;
              chk_vld_d = 1'b0;
              cnt_d     = '0;
              state_d   = S_SWP;
            end
          end else begin
            pkt_d.source = req_i.source_address;
            pkt_d.dest   = req_i.dest_address;
            pkt_d.proto  = req_i.proto_number;
            pkt_d.bytes  = req_i.byte_count;
            if (req_i.dest_address != cfg.home_addr && req_i.dest_address != cfg.alt_addr) begin
              pend_d          = '0;
              pend_d.kind     = KIND_STATUS;
              pend_d.status   = ST_SKIPPED;
              pend_d.source   = req_i.source_address;
              pend_d.dest     = req_i.dest_address;
              pend_d.proto    = req_i.proto_number;
              pend_vld_d      = 1'b1;
              state_d         = S_FLUSH;
            end else begin
              rd_idx_d   = '0;
              chk_vld_d  = 1'b0;
              free_fnd_d = 1'b0;
              state_d    = S_PKT;
            end
          end
        end
      end

      S_PKT: begin
        if (hit) begin
          mem_we     = 1'b1;
          mem_waddr  = chk_idx_q;
          mem_wdata  = upd;
          pend_d     = rec_of(upd, KIND_STATUS, ST_UPDATED, CAUSE_IDLE);
          pend_vld_d = 1'b1;
          state_d    = S_FLUSH;
        end else if (!chk_vld_q && !rd_more) begin
          pend_vld_d = 1'b1;
          state_d    = S_FLUSH;
          if (free_fnd_q) begin
            mem_we                = 1'b1;
            valid_d[free_idx_q]   = 1'b1;
            pend_d = rec_of(crt, KIND_STATUS, ST_CREATED, CAUSE_IDLE);
          end else begin
            pend_d        = '0;
            pend_d.kind   = KIND_STATUS;
            pend_d.status = ST_FULL;
            pend_d.source = pkt_q.source;
            pend_d.dest   = pkt_q.dest;
            pend_d.proto  = pkt_q.proto;
          end
        end else begin
          // lowest free entry seen so far
          if (chk_vld_q && !valid_q[chk_idx_q] && !free_fnd_q) begin
            free_fnd_d = 1'b1;
            free_idx_d = chk_idx_q;
          end
          rd_en     = rd_more;
          chk_vld_d = rd_more;
          chk_idx_d = rd_idx_q[IW-1:0];
          if (rd_more) begin
            rd_idx_d = rd_idx_q + CW'(1);
          end
        end
      end

      S_SWP: begin
        if (!stall) begin
          rd_en     = rd_more;
          chk_vld_d = rd_more;
          chk_idx_d = rd_idx_q[IW-1:0];
          if (rd_more) begin
            rd_idx_d = rd_idx_q + CW'(1);
          end
          if (expire) begin
            // hand the held record on, keep this one back
            if (pend_vld_q) begin
              out_d     = pend_q;
              out_vld_d = 1'b1;
            end
            pend_d = rec_of(rd_q, KIND_EXPORT, ST_CREATED,
                            exp_idle ? CAUSE_IDLE : CAUSE_ACTIVE);
            pend_vld_d         = 1'b1;
            valid_d[chk_idx_q] = 1'b0;
            cnt_d              = cnt_q + NW'(1);
            if (cnt_q + NW'(1) == NW'(MaxResults)) begin
              state_d = S_FLUSH;
            end
          end
          if (!chk_vld_q && !rd_more) begin
            state_d = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_idx_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_idx_q   <= '0;
      chk_vld_q  <= 1'b0;
      valid_q    <= '0;
      free_fnd_q <= 1'b0;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      now_q      <= '0;
      swc_q      <= '0;
    end else begin
      state_q    <= state_d;
      rd_idx_q   <= rd_idx_d;
      chk_vld_q  <= chk_vld_d;
      valid_q    <= valid_d;
      free_fnd_q <= free_fnd_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      now_q      <= now_d;
      swc_q      <= swc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q  <= chk_idx_d;
    free_idx_q <= free_idx_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    pkt_q      <= pkt_d;
  end

  assign req_i.ready         = state_q == S_IDLE;
  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.record_kind   = out_q.kind;
  assign rsp_o.status        = out_q.status;
  assign rsp_o.flow_source   = out_q.source;
  assign rsp_o.flow_dest     = out_q.dest;
  assign rsp_o.flow_proto    = out_q.proto;
  assign rsp_o.flow_bytes    = out_q.bytes;
  assign rsp_o.flow_packets  = out_q.packets;
  assign rsp_o.flow_duration = out_q.duration;
  assign rsp_o.expire_cause  = out_q.cause;
  assign rsp_o.last_of_run   = out_q.last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(MaxResults))
    else $error("sweep export count above limit");

  a_create_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PKT && mem_we && !hit) |-> !valid_q[free_idx_q])
    else $error("new flow written over a valid entry");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !rsp_o.ready) |=> $stable(out_q))
    else $error("held result changed");

  a_stall_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWP && stall) |=> $stable(rd_q) && $stable(chk_idx_q))
    else $error("sweep advanced while stalled");

endmodule

// ----- tb/tb_flow_table_with_timeouts.sv -----
// testbench of the flow table with idle and active timeouts
`timescale 1ns / 100ps

module tb_flow_table_with_timeouts;
  import ftt_pkg::*;

  localparam int unsigned Depth      = 32;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainWait  = Depth + 12;
  localparam logic [CfgIdxW-1:0] UnusedIdx = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ftt_req_if req_if ();
  ftt_rsp_if rsp_if ();

  flow_table_with_timeouts #(.TABLE_DEPTH(Depth)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predicted flow table state
  cfg_t              flow_cfg;
  logic              flow_valid [Depth];
  entry_t            flow_entry [Depth];
  logic [TimeW-1:0]  now_seconds;
  logic [LimitW-1:0] ticks_since_sweep;
  rec_t              expected_records[$];

  int unsigned error_count;
  int unsigned requests_sent;
  int unsigned records_checked;
  int unsigned exports_seen;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned stall_mode;
  int unsigned stall_count;

  logic [AddrW-1:0] host_pool [6];

  initial begin
    clk_i = 1'b0;
  end
  always #6 clk_i = ~clk_i;

  task automatic report_error(input string what);
    error_count++;
    $display("tb: mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic rec_t entry_record(input int idx, input kind_e kind, input status_e st,
                                        input cause_e cause);
    rec_t r;
    r.kind     = kind;
    r.status   = st;
    r.source   = flow_entry[idx].source;
    r.dest     = flow_entry[idx].dest;
    r.proto    = flow_entry[idx].proto;
    r.bytes    = flow_entry[idx].bytes;
    r.packets  = flow_entry[idx].packets;
    r.duration = flow_entry[idx].last - flow_entry[idx].start;
    r.cause    = cause;
    r.last     = 1'b0;
    return r;
  endfunction

  function automatic rec_t packet_record(input status_e st, input pkt_t p);
    rec_t r;
    r          = '0;
    r.kind     = KIND_STATUS;
    r.status   = st;
    r.source   = p.source;
    r.dest     = p.dest;
    r.proto    = p.proto;
    return r;
  endfunction

  // computes the results of one accepted request and advances the table
  function automatic void predict_flow_table(input op_e op, input pkt_t p);
    rec_t             out[$];
    rec_t             r;
    logic [AddrW-1:0] lo, hi, elo, ehi;
    logic [BytesW:0]  sum;
    logic [TimeW-1:0] idle_age, flow_age;
    int               free_idx;
    int               hit_idx;
    if (op == OP_PACKET) begin
      lo = (p.source < p.dest) ? p.source : p.dest;
      hi = (p.source < p.dest) ? p.dest : p.source;
      free_idx = -1;
      hit_idx = -1;
      if (p.dest != flow_cfg.home_addr && p.dest != flow_cfg.alt_addr) begin
        out.push_back(packet_record(ST_SKIPPED, p));
      end else begin
        for (int i = 0; i < Depth && hit_idx < 0; i++) begin
          if (flow_valid[i]) begin
            elo = (flow_entry[i].source < flow_entry[i].dest) ?
                  flow_entry[i].source : flow_entry[i].dest;
            ehi = (flow_entry[i].source < flow_entry[i].dest) ?
                  flow_entry[i].dest : flow_entry[i].source;
            if (elo == lo && ehi == hi && flow_entry[i].proto == p.proto) hit_idx = i;
          end else if (free_idx < 0) begin
            free_idx = i;
          end
        end
        if (hit_idx >= 0) begin
          sum = flow_entry[hit_idx].bytes + p.bytes;
          flow_entry[hit_idx].bytes = sum > BytesMax ? BytesMax : sum[BytesW-1:0];
          if (flow_entry[hit_idx].packets != PacketsMax) flow_entry[hit_idx].packets++;
          flow_entry[hit_idx].last = now_seconds;
          out.push_back(entry_record(hit_idx, KIND_STATUS, ST_UPDATED, CAUSE_IDLE));
        end else if (free_idx < 0) begin
          out.push_back(packet_record(ST_FULL, p));
        end else begin
          flow_valid[free_idx]         = 1'b1;
          flow_entry[free_idx].source  = p.source;
          flow_entry[free_idx].dest    = p.dest;
          flow_entry[free_idx].proto   = p.proto;
          flow_entry[free_idx].bytes   = BytesW'(p.bytes);
          flow_entry[free_idx].packets = CountW'(1);
          flow_entry[free_idx].start   = now_seconds;
          flow_entry[free_idx].last    = now_seconds;
          out.push_back(entry_record(free_idx, KIND_STATUS, ST_CREATED, CAUSE_IDLE));
        end
      end
    end else begin
      now_seconds++;
      ticks_since_sweep++;
      if (ticks_since_sweep >= flow_cfg.period) begin
        ticks_since_sweep = '0;
        for (int i = 0; i < Depth && out.size() < MaxResults; i++) begin
          if (flow_valid[i]) begin
            idle_age = now_seconds - flow_entry[i].last;
            flow_age = now_seconds - flow_entry[i].start;
            // idle wins over active when both have run out
            if (idle_age >= flow_cfg.idle_lim) begin
              out.push_back(entry_record(i, KIND_EXPORT, ST_CREATED, CAUSE_IDLE));
              flow_valid[i] = 1'b0;
            end else if (flow_age >= flow_cfg.act_lim) begin
              out.push_back(entry_record(i, KIND_EXPORT, ST_CREATED, CAUSE_ACTIVE));
              flow_valid[i] = 1'b0;
            end
          end
        end
      end
    end
    if (out.size() > 0) begin
      r = out.pop_back();
      r.last = 1'b1;
      out.push_back(r);
    end
    foreach (out[k]) expected_records.push_back(out[k]);
  endfunction

  // one request, sent in bursts with random gaps in between
  task automatic send_request(input op_e op, input logic [AddrW-1:0] src,
                              input logic [AddrW-1:0] dst, input logic [ProtoW-1:0] proto,
                              input logic [PktByteW-1:0] nbytes);
    pkt_t p;
    int   gap;
    p.source = src;
    p.dest   = dst;
    p.proto  = proto;
    p.bytes  = nbytes;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    req_if.operation      = op;
    req_if.source_address = src;
    req_if.dest_address   = dst;
    req_if.proto_number   = proto;
    req_if.byte_count     = nbytes;
    req_if.valid          = 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predict_flow_table(op, p);
    requests_sent++;
    @(negedge clk_i);
    req_if.valid = 1'b0;
  endtask

  task automatic send_packet(input logic [AddrW-1:0] src, input logic [AddrW-1:0] dst,
                             input logic [ProtoW-1:0] proto,
                             input logic [PktByteW-1:0] nbytes);
    send_request(OP_PACKET, src, dst, proto, nbytes);
  endtask

  task automatic send_tick();
    send_request(OP_TICK, $urandom(), $urandom(), ProtoW'($urandom()),
                 PktByteW'($urandom()));
  endtask

  task automatic wait_idle();
    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_LOCAL_ADDR: flow_cfg.home_addr = data;
      REG_ALT_ADDR:   flow_cfg.alt_addr  = data;
      REG_IDLE_LIM:   flow_cfg.idle_lim  = data[LimitW-1:0];
      REG_ACT_LIM:    flow_cfg.act_lim   = data[LimitW-1:0];
      REG_PERIOD:     flow_cfg.period    = data[LimitW-1:0];
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk_i) begin : check_results
    rec_t e;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      records_checked++;
      if (rsp_if.record_kind == KIND_EXPORT) exports_seen++;
      if (expected_records.size() == 0) begin
        report_error("result with nothing expected");
      end else begin
        e = expected_records.pop_front();
        if (rsp_if.record_kind !== e.kind)
          report_error($sformatf("record_kind %0d, want %0d", rsp_if.record_kind, e.kind));
        if (rsp_if.status !== e.status)
          report_error($sformatf("status %0d, want %0d", rsp_if.status, e.status));
        if (rsp_if.flow_source !== e.source)
          report_error($sformatf("flow_source %h, want %h", rsp_if.flow_source, e.source));
        if (rsp_if.flow_dest !== e.dest)
          report_error($sformatf("flow_dest %h, want %h", rsp_if.flow_dest, e.dest));
        if (rsp_if.flow_proto !== e.proto)
          report_error($sformatf("flow_proto %h, want %h", rsp_if.flow_proto, e.proto));
        if (rsp_if.flow_bytes !== e.bytes)
          report_error($sformatf("flow_bytes %h, want %h", rsp_if.flow_bytes, e.bytes));
        if (rsp_if.flow_packets !== e.packets)
          report_error($sformatf("flow_packets %0d, want %0d", rsp_if.flow_packets,
                                 e.packets));
        if (rsp_if.flow_duration !== e.duration)
          report_error($sformatf("flow_duration %0d, want %0d", rsp_if.flow_duration,
                                 e.duration));
        if (rsp_if.expire_cause !== e.cause)
          report_error($sformatf("expire_cause %0d, want %0d", rsp_if.expire_cause, e.cause));
        if (rsp_if.last_of_run !== e.last)
          report_error($sformatf("last_of_run %0d, want %0d", rsp_if.last_of_run, e.last));
      end
    end
  end

  // receiver stall pattern: free running, random, or mostly stalled
  always @(negedge clk_i) begin
    if (stall_count == 0) begin
      stall_mode  = $urandom_range(0, 2);
      stall_count = $urandom_range(20, 150);
    end
    stall_count--;
    case (stall_mode)
      0:       rsp_if.ready = 1'b1;
      1:       rsp_if.ready = 1'($urandom_range(0, 1));
      default: rsp_if.ready = ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_packet_status();
    send_packet(32'h0A00_0001, 32'h0A00_0002, 8'd6, 16'd100);      // foreign destination
    send_packet(32'hFFFF_FFFF, AltAddrRst, 8'd255, 16'hFFFF);
    send_packet(AltAddrRst, 32'hFFFF_FFFF, 8'd255, 16'd1);        // reverse direction to a foreign destination, skipped
    send_packet(32'h0000_0000, 32'h0000_0000, 8'd0, 16'd0);       // local address of zero
    send_packet(32'h0000_0000, 32'h0000_0000, 8'd1, 16'd5);       // other protocol, new flow
    send_packet(32'h0000_0000, 32'h0000_0000, 8'd0, 16'hFFFF);
    wait_idle();
    write_reg(UnusedIdx, 32'hDEAD_BEEF);                          // ignored index
    send_packet(32'h1234_5678, 32'hDEAD_BEEF, 8'd17, 16'd9);
  endtask

  task automatic test_table_full();
    wait_idle();
    write_reg(REG_IDLE_LIM, 32'd1);
    write_reg(REG_PERIOD, 32'd1);
    send_tick();                                                  // flush
    for (int i = 0; i < Depth; i++) begin
      send_packet(AddrW'(32'h0B00_0000 + i), 32'h0, 8'd6, PktByteW'(i));
    end
    send_packet(32'h0C00_0000, AltAddrRst, 8'd6, 16'd7);          // no free entry
    send_tick();                                                  // exports all 32 at once
  endtask

  task automatic test_active_timeout();
    wait_idle();
    write_reg(REG_IDLE_LIM, 32'd100);
    write_reg(REG_ACT_LIM, 32'd3);
    send_packet(32'h0D00_0001, AltAddrRst, 8'd17, 16'd40);
    send_tick();
    send_packet(AltAddrRst, 32'h0D00_0001, 8'd17, 16'd40);
    send_tick();
    send_packet(32'h0D00_0001, AltAddrRst, 8'd17, 16'd40);
    send_tick();
  endtask

  task automatic test_period_change();
    wait_idle();
    write_reg(REG_IDLE_LIM, 32'd2);
    write_reg(REG_PERIOD, 32'd10);
    send_packet(32'h0E00_0001, 32'h0, 8'd1, 16'd3);
    repeat (5) send_tick();
    wait_idle();
    write_reg(REG_PERIOD, 32'd3);                                 // below the tick count
    send_tick();
  endtask

  task automatic test_random_traffic();
    logic [AddrW-1:0]  src, dst, tmp;
    logic [ProtoW-1:0] proto;
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      write_reg(REG_LOCAL_ADDR, $urandom());
      write_reg(REG_ALT_ADDR, (phase == 5) ? 32'hFFFF_FFFF : $urandom());
      case (phase)
        0: begin
          write_reg(REG_IDLE_LIM, 32'd65535);
          write_reg(REG_ACT_LIM, 32'd65535);
          write_reg(REG_PERIOD, 32'd65535);
        end
        1: begin
          write_reg(REG_IDLE_LIM, 32'd1);
          write_reg(REG_ACT_LIM, 32'd1);
          write_reg(REG_PERIOD, 32'd1);
        end
        default: begin
          write_reg(REG_IDLE_LIM, $urandom_range(1, 8));
          write_reg(REG_ACT_LIM, $urandom_range(2, 20));
          write_reg(REG_PERIOD, $urandom_range(1, 4));
        end
      endcase
      foreach (host_pool[k]) host_pool[k] = $urandom();
      for (int n = 0; n < 40; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          send_tick();
        end else begin
          src = ($urandom_range(0, 4) == 0) ? $urandom() : host_pool[$urandom_range(0, 5)];
          case ($urandom_range(0, 9))
            0, 1:    dst = $urandom();
            2, 3, 4: dst = flow_cfg.alt_addr;
            default: dst = flow_cfg.home_addr;
          endcase
          proto = ($urandom_range(0, 3) == 0) ? ProtoW'($urandom())
                                              : ($urandom_range(0, 1) ? 8'd6 : 8'd17);
          // occasionally reverse source and destination
          if ($urandom_range(0, 7) == 0) begin
            tmp = src;
            src = dst;
            dst = tmp;
          end
          send_packet(src, dst, proto, PktByteW'($urandom()));
        end
      end
    end
  endtask

  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = '0;
    cfg_data_i            = '0;
    req_if.valid          = 1'b0;
    req_if.operation      = OP_PACKET;
    req_if.source_address = '0;
    req_if.dest_address   = '0;
    req_if.proto_number   = '0;
    req_if.byte_count     = '0;
    rsp_if.ready          = 1'b0;
    error_count     = 0;
    requests_sent   = 0;
    records_checked = 0;
    exports_seen    = 0;
    cycle_count     = 0;
    burst_left      = 0;
    stall_mode      = 0;
    stall_count     = 0;
    flow_cfg.home_addr = LocalAddrRst;
    flow_cfg.alt_addr  = AltAddrRst;
    flow_cfg.idle_lim  = IdleLimRst;
    flow_cfg.act_lim   = ActLimRst;
    flow_cfg.period    = PeriodRst;
    foreach (flow_valid[i]) flow_valid[i] = 1'b0;
    now_seconds       = '0;
    ticks_since_sweep = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_packet_status();
    test_table_full();
    test_active_timeout();
    test_period_change();
    test_random_traffic();

    wait_idle();
    $display("tb: %0d requests sent, %0d results checked, %0d of them exported flows",
             requests_sent, records_checked, exports_seen);
    $display("tb: covered skip, create, update, table full, idle and active expiry");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- flow_table_with_timeouts.f -----
hdl/ftt_pkg.sv
hdl/ftt_if.sv
hdl/ftt_cfg.sv
hdl/flow_table_with_timeouts.sv
tb/tb_flow_table_with_timeouts.sv
